>>> rtl/core/uidp_pkg.sv
package uidp_pkg;

  // wire constants
  localparam logic [7:0]  SyncByte = 8'h80;
  localparam logic [7:0]  PidData1 = 8'h4B;
  localparam logic [7:0]  PidData0 = 8'hC3;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  // default packet size and command queue depth
  localparam int unsigned MaxPacketBytesDefault = 8;
  localparam int unsigned CmdDepth = 4;

  // one classified input word, handed from front to back
  typedef struct packed {
    logic        open;       // emit sync and pid first
    logic        pid_data1;  // pid is data1, else data0
    logic        has_data;   // emit the data byte
    logic        close;      // emit the two crc bytes
    logic [7:0]  data;
    logic [15:0] crc;        // inverted crc, valid when close is set
  } cmd_t;

  // usb crc16 over one byte, reflected, lsb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/uidp_front.sv
module uidp_front #(
  parameter int unsigned MAX_PACKET_BYTES = uidp_pkg::MaxPacketBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  logic [7:0]     payload_byte_i,
  input  logic           last_byte_i,
  input  logic           empty_transfer_i,
  output uidp_pkg::cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);

  logic [15:0]     crc_q, crc_d;
  logic            toggle_q, toggle_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [15:0]     crc_base;
  logic [15:0]     crc_new;
  logic [CntW-1:0] cnt_next;
  logic            open;
  logic            close;

  // classify the word and advance the packet state
  always_comb begin
    open     = (cnt_q == '0);
    crc_base = open ? uidp_pkg::CrcInit : crc_q;
    crc_new  = uidp_pkg::crc16_byte(crc_base, payload_byte_i);
    cnt_next = cnt_q + 1'b1;
    close    = last_byte_i || (cnt_next == CntW'(MAX_PACKET_BYTES));

    crc_d    = crc_q;
    toggle_d = toggle_q;
    cnt_d    = cnt_q;

    if (empty_transfer_i) begin
      cmd_o.open      = 1'b1;
      cmd_o.pid_data1 = 1'b1;
      cmd_o.has_data  = 1'b0;
      cmd_o.close     = 1'b1;
      cmd_o.data      = 8'h00;
      cmd_o.crc       = 16'h0000;
      crc_d    = uidp_pkg::CrcInit;
      toggle_d = 1'b1;
      cnt_d    = '0;
    end else begin
      cmd_o.open      = open;
      cmd_o.pid_data1 = toggle_q;
      cmd_o.has_data  = 1'b1;
      cmd_o.close     = close;
      cmd_o.data      = payload_byte_i;
      cmd_o.crc       = ~crc_new;
      if (close) begin
        crc_d    = uidp_pkg::CrcInit;
        toggle_d = last_byte_i ? 1'b1 : ~toggle_q;
        cnt_d    = '0;
      end else begin
        crc_d = crc_new;
        cnt_d = cnt_next;
      end
    end
  end

  // packet state, updated on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= uidp_pkg::CrcInit;
      toggle_q <= 1'b1;
      cnt_q    <= '0;
    end else if (in_valid_i && in_ready_i) begin
      crc_q    <= crc_d;
      toggle_q <= toggle_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/core/uidp_fifo.sv
module uidp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  uidp_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output uidp_pkg::cmd_t head_cmd_o
);

  localparam int unsigned Depth = uidp_pkg::CmdDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  uidp_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> rtl/core/uidp_back.sv
module uidp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  uidp_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     packet_byte_o,
  output logic           packet_end_o
);

  typedef enum logic [2:0] {
    PhSync,
    PhPid,
    PhData,
    PhCrcLo,
    PhCrcHi
  } phase_e;

  phase_e     phase_q, phase_d, eff;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       end_q, end_d;
  logic       advance;
  logic       cmd_done;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && cmd_done;

  // skip phases the command does not need, pick the byte and the next phase
  always_comb begin
    eff = phase_q;
    if (eff == PhSync && !head_cmd_i.open)    eff = PhData;
    if (eff == PhData && !head_cmd_i.has_data) eff = PhCrcLo;

    byte_d   = 8'h00;
    end_d    = 1'b0;
    cmd_done = 1'b0;
    phase_d  = phase_q;
    unique case (eff)
      PhSync: begin
        byte_d  = uidp_pkg::SyncByte;
        phase_d = PhPid;
      end
      PhPid: begin
        byte_d  = head_cmd_i.pid_data1 ? uidp_pkg::PidData1 : uidp_pkg::PidData0;
        phase_d = PhData;
      end
      PhData: begin
        byte_d = head_cmd_i.data;
        if (head_cmd_i.close) begin
          phase_d = PhCrcLo;
        end else begin
          cmd_done = 1'b1;
          phase_d  = PhSync;
        end
      end
      PhCrcLo: begin
        byte_d  = head_cmd_i.crc[7:0];
        phase_d = PhCrcHi;
      end
      PhCrcHi: begin
        byte_d   = head_cmd_i.crc[15:8];
        end_d    = 1'b1;
        cmd_done = 1'b1;
        phase_d  = PhSync;
      end
      default: begin
        phase_d = PhSync;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSync;
      out_valid_q <= 1'b0;
      byte_q      <= 8'h00;
      end_q       <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
        byte_q      <= byte_d;
        end_q       <= end_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packet_byte_o = byte_q;
  assign packet_end_o  = end_q;

endmodule

>>> rtl/core/usb_in_data_packetizer.sv
// USB IN data packetizer: takes payload bytes of an IN transfer on the slave
// stream and emits wire bytes on the master stream, packets of up to
// MAX_PACKET_BYTES data bytes framed as sync 0x80, DATA PID (DATA1 first,
// then alternating), data, inverted CRC16 low byte then high byte (tlast set
// on the high byte). tuser on the input requests the zero-length DATA1 packet
// 80 4B 00 00 and resets the toggle. The front stage takes a word
// whenever the four-entry command queue has room; the output sequencer sends
// one wire byte per cycle while it holds a command and the master stream is
// ready, so a payload byte gives 1 wire byte inside a packet, 3 when it opens
// or closes a packet, 5 when it does both, and an empty transfer gives 4.
module usb_in_data_packetizer #(
  parameter int unsigned MAX_PACKET_BYTES = uidp_pkg::MaxPacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] payload_byte
  input  logic       s_axis_tlast_i,  // last_byte
  input  logic       s_axis_tuser_i,  // [0] empty_transfer
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] packet_byte
  output logic       m_axis_tlast_o   // packet_end
);

  uidp_pkg::cmd_t push_cmd;
  uidp_pkg::cmd_t head_cmd;
  logic           full;
  logic           head_valid;
  logic           pop;

  assign s_axis_tready_o = !full;

  // classify input words
  uidp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_i      (s_axis_tready_o),
    .payload_byte_i  (s_axis_tdata_i),
    .last_byte_i     (s_axis_tlast_i),
    .empty_transfer_i(s_axis_tuser_i),
    .cmd_o           (push_cmd)
  );

  // command queue
  uidp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_cmd_i  (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_cmd_o  (head_cmd)
  );

  // wire byte sequencer
  uidp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .packet_byte_o(m_axis_tdata_o),
    .packet_end_o (m_axis_tlast_o)
  );

endmodule

>>> dv/uidp_stream_checker.sv
`timescale 1ns / 1ps

module uidp_stream_checker #(
  parameter int unsigned MAX_PACKET_BYTES = uidp_pkg::MaxPacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream, observed
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] payload_byte
  input  logic       s_axis_tlast_i,  // last_byte
  input  logic       s_axis_tuser_i,  // [0] empty_transfer
  // output stream, observed
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,  // [7:0] packet_byte
  input  logic       m_axis_tlast_i,  // packet_end
  output int         err_cnt_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       pkt_end;
  } wire_word_t;

  // wire bytes still owed by the block, oldest first
  wire_word_t  wire_bytes_q[$];

  // predicted packetizer state
  logic [15:0] pkt_crc;
  logic        pid_is_data1;
  logic [6:0]  pkt_data_cnt;
  int          err_n;

  // crc16 update, one input bit at a time
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ uidp_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic owe_wire_byte(input logic [7:0] b, input logic e);
    wire_bytes_q.push_back(wire_word_t'{wire_byte: b, pkt_end: e});
  endtask

  task automatic clear_packet_state();
    pkt_crc      = uidp_pkg::CrcInit;
    pid_is_data1 = 1'b1;
    pkt_data_cnt = '0;
  endtask

  // work out the wire bytes caused by one accepted input word
  task automatic predict_wire_bytes(input logic [7:0] data, input logic last,
                                    input logic empty);
    logic [15:0] crc_out;
    if (empty) begin
      owe_wire_byte(uidp_pkg::SyncByte, 1'b0);
      owe_wire_byte(uidp_pkg::PidData1, 1'b0);
      owe_wire_byte(8'h00, 1'b0);
      owe_wire_byte(8'h00, 1'b1);
      clear_packet_state();
    end else begin
      // open a packet
      if (pkt_data_cnt == 0) begin
        owe_wire_byte(uidp_pkg::SyncByte, 1'b0);
        owe_wire_byte(pid_is_data1 ? uidp_pkg::PidData1 : uidp_pkg::PidData0, 1'b0);
        pkt_crc = uidp_pkg::CrcInit;
      end
      owe_wire_byte(data, 1'b0);
      pkt_crc      = crc16_next(pkt_crc, data);
      pkt_data_cnt = pkt_data_cnt + 7'd1;
      // close on last byte or full packet
      if (last || pkt_data_cnt >= MAX_PACKET_BYTES) begin
        crc_out = ~pkt_crc;
        owe_wire_byte(crc_out[7:0], 1'b0);
        owe_wire_byte(crc_out[15:8], 1'b1);
        pkt_data_cnt = '0;
        pkt_crc      = uidp_pkg::CrcInit;
        pid_is_data1 = last ? 1'b1 : ~pid_is_data1;
      end
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    wire_word_t want;
    if (!rst_ni) begin
      wire_bytes_q.delete();
      clear_packet_state();
      err_n     = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_wire_bytes(s_axis_tdata_i, s_axis_tlast_i, s_axis_tuser_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (wire_bytes_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual byte %02h end %0b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          err_n++;
        end else begin
          want = wire_bytes_q.pop_front();
          if (m_axis_tdata_i !== want.wire_byte) begin
            $display("%0t: packet_byte mismatch, expected %02h actual %02h",
                     $time, want.wire_byte, m_axis_tdata_i);
            err_n++;
          end
          if (m_axis_tlast_i !== want.pkt_end) begin
            $display("%0t: packet_end mismatch, expected %0b actual %0b",
                     $time, want.pkt_end, m_axis_tlast_i);
            err_n++;
          end
        end
      end
      err_cnt_o <= err_n;
      pending_o <= wire_bytes_q.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] payload_byte
  logic       s_axis_tlast = 1'b0;   // last_byte
  logic       s_axis_tuser = 1'b0;   // [0] empty_transfer
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] packet_byte
  logic       m_axis_tlast;          // packet_end
  int         err_cnt;
  int         pending;

  // stimulus knobs shared by sender and receiver
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  bit hold_off_req = 1'b0;
  bit pressure_done = 1'b0;
  int items_sent = 0;

  usb_in_data_packetizer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  uidp_stream_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one payload word, wait for it to be taken
  task automatic send_word(input logic [7:0] data, input logic last, input logic empty);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // a run of payload bytes, last flag on the final one if closed
  task automatic send_transfer(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_word(8'($urandom_range(0, 255)), closed && (i == len - 1), 1'b0);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    int words;
    words = 0;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        stall = sink_stalls_on ? $urandom_range(0, 16) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      words++;
      if (words % 48 == 0) begin
        sink_stalls_on = ($urandom_range(0, 2) != 0);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int pick;
    int len;
    int waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty transfer, last flag and data ignored
    send_word(8'hFF, 1'b1, 1'b1);
    // one-byte transfers at both data extremes
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    // one byte past a full packet: data1 then data0
    for (int i = 0; i <= uidp_pkg::MaxPacketBytesDefault; i++) begin
      send_word(8'(8'h1D * i), i == uidp_pkg::MaxPacketBytesDefault, 1'b0);
    end
    // last byte lands on a full packet
    for (int i = 0; i < uidp_pkg::MaxPacketBytesDefault; i++) begin
      send_word(8'(8'hA5 ^ i), i == uidp_pkg::MaxPacketBytesDefault - 1, 1'b0);
    end
    // empty transfer drops an open packet
    send_word(8'h3C, 1'b0, 1'b0);
    send_word(8'hC3, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);

    // random transfers, mostly well formed
    while (items_sent < 430) begin
      src_gaps_on = ($urandom_range(0, 3) != 0);
      if (!pressure_done && items_sent >= 150) begin
        // receiver holds off while a long burst keeps coming
        pressure_done = 1'b1;
        src_gaps_on   = 1'b0;
        hold_off_req  = 1'b1;
        send_transfer(40, 1'b1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick == 1) begin
          send_transfer($urandom_range(1, 12), 1'b0);
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 20);
          send_transfer(len, 1'b1);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    waited = 0;
    repeat (2) @(posedge clk_i);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending);
    end
    if (err_cnt == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
